// File: sv/sqi_pkg.sv
`default_nettype none
package sqi_pkg;

  // field and register widths
  localparam int COORD_WIDTH  = 21;
  localparam int T_FRAC_BITS  = 16;
  localparam int IN_FIELD_W   = 21;
  localparam int NORM_W       = 16;
  localparam int VERT_W       = 63;
  localparam int NORMAL_REG_W = 48;
  localparam int TOL_W        = 20;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 63;
  localparam int IN_TDATA_W   = 128;
  localparam int OUT_TDATA_W  = 8;
  localparam int QUEUE_DEPTH  = 4;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VERTEX_ONE   = 3'd0,
    REG_VERTEX_TWO   = 3'd1,
    REG_VERTEX_THREE = 3'd2,
    REG_VERTEX_FOUR  = 3'd3,
    REG_PLANE_NORMAL = 3'd4,
    REG_TOLERANCE    = 3'd5
  } cfg_reg_t;

  // configuration register group
  typedef struct packed {
    logic [VERT_W-1:0]       v1;
    logic [VERT_W-1:0]       v2;
    logic [VERT_W-1:0]       v3;
    logic [VERT_W-1:0]       v4;
    logic [NORMAL_REG_W-1:0] normal;
    logic [TOL_W-1:0]        tol;
  } cfg_t;

  localparam logic [NORMAL_REG_W-1:0] NORMAL_RESET = 48'h4000_0000_0000;
  localparam logic [TOL_W-1:0]        TOL_RESET    = 20'd1;

endpackage
`default_nettype wire

// File: sv/sqi_front.sv
`default_nettype none
module sqi_front #(
  parameter int COORD_WIDTH = sqi_pkg::COORD_WIDTH,
  parameter int T_FRAC_BITS = sqi_pkg::T_FRAC_BITS
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire sqi_pkg::cfg_t                      cfg,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [sqi_pkg::IN_TDATA_W-1:0]     in_data,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [T_FRAC_BITS+6*COORD_WIDTH+4:0]    out_item
);
  import sqi_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int TF  = T_FRAC_BITS;
  localparam int XW  = CW + 1;
  localparam int PRW = XW + NORM_W;
  localparam int DW  = CW + 19;
  localparam int NW  = CW + 20;
  localparam int AB  = TF + 2;
  localparam int DB  = AB + 3 * CW;

  logic en;

  logic signed [CW-1:0]     v0 [3];
  logic signed [NORM_W-1:0] nrm [3];
  logic signed [CW-1:0]     a_in [3];
  logic signed [CW-1:0]     b_in [3];

  logic                 s1_vld_r, s2_vld_r, s3_vld_r;
  logic signed [XW-1:0] s1_ea_r [3];
  logic signed [XW-1:0] s1_eb_r [3];
  logic signed [CW-1:0] s1_a_r [3];
  logic signed [XW-1:0] s1_d_r [3];
  logic signed [PRW-1:0] s2_pa_r [3];
  logic signed [PRW-1:0] s2_pb_r [3];
  logic signed [PRW-1:0] s2_pd_r [3];
  logic signed [CW-1:0]  s2_a_r [3];
  logic signed [XW-1:0]  s2_d_r [3];
  logic signed [DW-1:0]  s3_da_r, s3_db_r;
  logic signed [NW-1:0]  s3_den_r;
  logic signed [CW-1:0]  s3_a_r [3];
  logic signed [XW-1:0]  s3_d_r [3];

  logic              dv_vld_r [TF+1];
  logic [NW-1:0]     dv_rem_r [TF+1];
  logic [NW-1:0]     dv_den_r [TF+1];
  logic [TF-1:0]     dv_q_r [TF+1];
  logic              dv_rej_r [TF+1];
  logic              dv_eq_r [TF+1];
  logic signed [CW-1:0] dv_a_r [TF+1][3];
  logic signed [XW-1:0] dv_d_r [TF+1][3];

  logic signed [NW-1:0] da_x, db_x, tol_x, abs_a, abs_b, abs_den;
  logic                 rej, eq;
  logic [TF:0]          t_fin;

  assign en       = !dv_vld_r[TF] || out_ready;
  assign in_ready = en;

  // unpack corner one, normal and the segment endpoints
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      v0[i]   = cfg.v1[i*CW +: CW];
      nrm[i]  = cfg.normal[i*NORM_W +: NORM_W];
      a_in[i] = in_data[i*IN_FIELD_W +: CW];
      b_in[i] = in_data[(i+3)*IN_FIELD_W +: CW];
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      for (int k = 0; k <= TF; k++) dv_vld_r[k] <= 1'b0;
    end else if (en) begin
      s1_vld_r    <= in_valid;
      s2_vld_r    <= s1_vld_r;
      s3_vld_r    <= s2_vld_r;
      dv_vld_r[0] <= s3_vld_r;
      for (int k = 1; k <= TF; k++) dv_vld_r[k] <= dv_vld_r[k-1];
    end
  end

  // offsets from corner one and segment direction
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_ea_r[i] <= XW'(a_in[i]) - XW'(v0[i]);
        s1_eb_r[i] <= XW'(b_in[i]) - XW'(v0[i]);
        s1_a_r[i]  <= a_in[i];
        s1_d_r[i]  <= XW'(b_in[i]) - XW'(a_in[i]);
      end
    end
  end

  // products with the normal
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s2_pa_r[i] <= PRW'(s1_ea_r[i]) * PRW'(nrm[i]);
        s2_pb_r[i] <= PRW'(s1_eb_r[i]) * PRW'(nrm[i]);
        s2_pd_r[i] <= PRW'(s1_d_r[i]) * PRW'(nrm[i]);
        s2_a_r[i]  <= s1_a_r[i];
        s2_d_r[i]  <= s1_d_r[i];
      end
    end
  end

  // plane distances; da - db is minus the direction dot normal
  always_ff @(posedge clk) begin
    if (en) begin
      s3_da_r  <= DW'(s2_pa_r[0]) + DW'(s2_pa_r[1]) + DW'(s2_pa_r[2]);
      s3_db_r  <= DW'(s2_pb_r[0]) + DW'(s2_pb_r[1]) + DW'(s2_pb_r[2]);
      s3_den_r <= -(NW'(s2_pd_r[0]) + NW'(s2_pd_r[1]) + NW'(s2_pd_r[2]));
      for (int i = 0; i < 3; i++) begin
        s3_a_r[i] <= s2_a_r[i];
        s3_d_r[i] <= s2_d_r[i];
      end
    end
  end

  // classify: early rejects and the exact range check on t
  always_comb begin
    da_x    = NW'(s3_da_r);
    db_x    = NW'(s3_db_r);
    tol_x   = $signed(NW'(cfg.tol));
    abs_a   = da_x[NW-1] ? -da_x : da_x;
    abs_b   = db_x[NW-1] ? -db_x : db_x;
    abs_den = s3_den_r[NW-1] ? -s3_den_r : s3_den_r;
    rej = (da_x > tol_x && db_x > tol_x) ||
          (da_x < -tol_x && db_x < -tol_x) ||
          (abs_a < tol_x && abs_b < tol_x) ||
          (abs_den < tol_x) ||
          (s3_den_r == '0) ||
          (da_x != '0 && (da_x[NW-1] != s3_den_r[NW-1])) ||
          (abs_a > abs_den);
    eq  = (abs_a == abs_den);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_rem_r[0] <= abs_a;
      dv_den_r[0] <= abs_den;
      dv_q_r[0]   <= '0;
      dv_rej_r[0] <= rej;
      dv_eq_r[0]  <= eq;
      for (int i = 0; i < 3; i++) begin
        dv_a_r[0][i] <= s3_a_r[i];
        dv_d_r[0][i] <= s3_d_r[i];
      end
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar k = 1; k <= TF; k++) begin : g_div
    logic [NW:0] rem2;
    logic [NW:0] diff;
    logic        ge;
    assign rem2 = {dv_rem_r[k-1], 1'b0};
    assign diff = rem2 - {1'b0, dv_den_r[k-1]};
    assign ge   = rem2 >= {1'b0, dv_den_r[k-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem_r[k] <= ge ? diff[NW-1:0] : rem2[NW-1:0];
        dv_den_r[k] <= dv_den_r[k-1];
        dv_q_r[k]   <= {dv_q_r[k-1][TF-2:0], ge};
        dv_rej_r[k] <= dv_rej_r[k-1];
        dv_eq_r[k]  <= dv_eq_r[k-1];
        for (int i = 0; i < 3; i++) begin
          dv_a_r[k][i] <= dv_a_r[k-1][i];
          dv_d_r[k][i] <= dv_d_r[k-1][i];
        end
      end
    end
  end

  // t = 1.0 exactly when numerator equals denominator
  assign t_fin = dv_eq_r[TF] ? {1'b1, {TF{1'b0}}} : {1'b0, dv_q_r[TF]};

  always_comb begin
    out_item          = '0;
    out_item[0]       = dv_rej_r[TF];
    out_item[TF+1:1]  = t_fin;
    for (int i = 0; i < 3; i++) begin
      out_item[AB+i*CW +: CW] = dv_a_r[TF][i];
      out_item[DB+i*XW +: XW] = dv_d_r[TF][i];
    end
  end

  assign out_valid = dv_vld_r[TF];

endmodule
`default_nettype wire

// File: sv/sqi_queue.sv
`default_nettype none
module sqi_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = sqi_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [WIDTH-1:0] in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [WIDTH-1:0]      out_data
);
  import sqi_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CNW-1:0]   cnt_r;
  logic             push, pop;

  assign in_ready  = cnt_r != CNW'(DEPTH);
  assign out_valid = cnt_r != '0;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_data  = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= in_data;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule
`default_nettype wire

// File: sv/sqi_back.sv
`default_nettype none
module sqi_back #(
  parameter int COORD_WIDTH = sqi_pkg::COORD_WIDTH,
  parameter int T_FRAC_BITS = sqi_pkg::T_FRAC_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire sqi_pkg::cfg_t                    cfg,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [T_FRAC_BITS+6*COORD_WIDTH+4:0] in_item,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [sqi_pkg::OUT_TDATA_W-1:0]       out_data
);
  import sqi_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int TF  = T_FRAC_BITS;
  localparam int XW  = CW + 1;
  localparam int MW  = XW + TF + 1;
  localparam int PW  = CW + 2;
  localparam int QW  = PW + 1;
  localparam int XPW = XW + QW;
  localparam int CXW = XPW + 1;
  localparam int DPW = CXW + NORM_W;
  localparam int SW  = DPW + 2;
  localparam int AB  = TF + 2;
  localparam int DB  = AB + 3 * CW;
  localparam logic [MW-1:0] HALF = {{(MW-1){1'b0}}, 1'b1} << (TF - 1);

  logic en;

  logic signed [CW-1:0]     vtx [4][3];
  logic signed [XW-1:0]     edg [4][3];
  logic signed [NORM_W-1:0] nrm [3];

  logic                 it_rej;
  logic [TF:0]          it_t;
  logic signed [CW-1:0] it_a [3];
  logic signed [XW-1:0] it_d [3];
  logic [XW-1:0]        abs_d [3];

  logic                 k1_vld_r, k2_vld_r, k3_vld_r, k4_vld_r, k5_vld_r;
  logic                 k1_rej_r, k2_rej_r, k3_rej_r, k4_rej_r, k5_rej_r;
  logic [MW-1:0]        k1_m_r [3];
  logic                 k1_neg_r [3];
  logic signed [CW-1:0] k1_a_r [3];

  logic [MW-1:0]        rnd [3];
  logic signed [PW:0]   ax [3];
  logic signed [PW:0]   rx [3];
  logic signed [PW:0]   pw [3];
  logic signed [PW-1:0] p [3];

  logic signed [QW-1:0]  k2_q_r [4][3];
  logic signed [XPW-1:0] k3_pr_r [4][6];
  logic signed [CXW-1:0] k4_c_r [4][3];
  logic signed [DPW-1:0] k5_cn_r [4][3];

  logic signed [SW-1:0] esum [4];
  logic signed [SW-1:0] tol_x;
  logic [3:0]           e_ok;

  logic o_vld_r, o_cut_r;

  assign en       = !o_vld_r || out_ready;
  assign in_ready = en;

  // corners, edge vectors and normal from configuration
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vtx[0][i] = cfg.v1[i*CW +: CW];
      vtx[1][i] = cfg.v2[i*CW +: CW];
      vtx[2][i] = cfg.v3[i*CW +: CW];
      vtx[3][i] = cfg.v4[i*CW +: CW];
      nrm[i]    = cfg.normal[i*NORM_W +: NORM_W];
    end
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 3; i++) begin
        edg[k][i] = XW'(vtx[(k+1)%4][i]) - XW'(vtx[k][i]);
      end
    end
  end

  // unpack the queued item
  always_comb begin
    it_rej = in_item[0];
    it_t   = in_item[TF+1:1];
    for (int i = 0; i < 3; i++) begin
      it_a[i]  = in_item[AB+i*CW +: CW];
      it_d[i]  = in_item[DB+i*XW +: XW];
      abs_d[i] = it_d[i][XW-1] ? XW'(-it_d[i]) : XW'(it_d[i]);
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k1_vld_r <= 1'b0;
      k2_vld_r <= 1'b0;
      k3_vld_r <= 1'b0;
      k4_vld_r <= 1'b0;
      k5_vld_r <= 1'b0;
      o_vld_r  <= 1'b0;
    end else if (en) begin
      k1_vld_r <= in_valid;
      k2_vld_r <= k1_vld_r;
      k3_vld_r <= k2_vld_r;
      k4_vld_r <= k3_vld_r;
      k5_vld_r <= k4_vld_r;
      o_vld_r  <= k5_vld_r;
    end
  end

  // t times |direction|
  always_ff @(posedge clk) begin
    if (en) begin
      k1_rej_r <= it_rej;
      for (int i = 0; i < 3; i++) begin
        k1_m_r[i]   <= MW'(abs_d[i]) * MW'(it_t);
        k1_neg_r[i] <= it_d[i][XW-1];
        k1_a_r[i]   <= it_a[i];
      end
    end
  end

  // crossing point, rounded half away from zero
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd[i] = k1_m_r[i] + HALF;
      ax[i]  = (PW+1)'(k1_a_r[i]);
      rx[i]  = $signed({1'b0, rnd[i][MW-1:TF]});
      pw[i]  = k1_neg_r[i] ? ax[i] - rx[i] : ax[i] + rx[i];
      p[i]   = pw[i][PW-1:0];
    end
  end

  // point relative to each edge start
  always_ff @(posedge clk) begin
    if (en) begin
      k2_rej_r <= k1_rej_r;
      for (int k = 0; k < 4; k++) begin
        for (int i = 0; i < 3; i++) begin
          k2_q_r[k][i] <= QW'(p[i]) - QW'(vtx[k][i]);
        end
      end
    end
  end

  // cross product terms
  always_ff @(posedge clk) begin
    if (en) begin
      k3_rej_r <= k2_rej_r;
      for (int k = 0; k < 4; k++) begin
        k3_pr_r[k][0] <= XPW'(edg[k][1]) * XPW'(k2_q_r[k][2]);
        k3_pr_r[k][1] <= XPW'(edg[k][2]) * XPW'(k2_q_r[k][1]);
        k3_pr_r[k][2] <= XPW'(edg[k][2]) * XPW'(k2_q_r[k][0]);
        k3_pr_r[k][3] <= XPW'(edg[k][0]) * XPW'(k2_q_r[k][2]);
        k3_pr_r[k][4] <= XPW'(edg[k][0]) * XPW'(k2_q_r[k][1]);
        k3_pr_r[k][5] <= XPW'(edg[k][1]) * XPW'(k2_q_r[k][0]);
      end
    end
  end

  // cross product components
  always_ff @(posedge clk) begin
    if (en) begin
      k4_rej_r <= k3_rej_r;
      for (int k = 0; k < 4; k++) begin
        for (int i = 0; i < 3; i++) begin
          k4_c_r[k][i] <= CXW'(k3_pr_r[k][2*i]) - CXW'(k3_pr_r[k][2*i+1]);
        end
      end
    end
  end

  // dot with the normal
  always_ff @(posedge clk) begin
    if (en) begin
      k5_rej_r <= k4_rej_r;
      for (int k = 0; k < 4; k++) begin
        for (int i = 0; i < 3; i++) begin
          k5_cn_r[k][i] <= DPW'(k4_c_r[k][i]) * DPW'(nrm[i]);
        end
      end
    end
  end

  // edge tests pass at or above minus tolerance
  always_comb begin
    tol_x = $signed(SW'(cfg.tol));
    for (int k = 0; k < 4; k++) begin
      esum[k] = SW'(k5_cn_r[k][0]) + SW'(k5_cn_r[k][1]) + SW'(k5_cn_r[k][2]);
      e_ok[k] = esum[k] >= -tol_x;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en) o_cut_r <= !k5_rej_r && (&e_ok);
  end

  assign out_valid = o_vld_r;
  assign out_data  = {{(OUT_TDATA_W-1){1'b0}}, o_cut_r};

endmodule
`default_nettype wire

// File: sv/segment_quad_intersection.sv
// throughput: one segment per cycle unless out_tready backpressure stalls the pipeline
// the divider is a pipeline of one quotient bit per stage
// a four-entry queue between the divider front and the edge-test back lets each side stall
// reset (rst_n low, synchronous) empties the pipeline and the queue, clears corners to 0,
// sets the normal to +z and the tolerance to 1
`default_nettype none
module segment_quad_intersection #(
  parameter int COORD_WIDTH = sqi_pkg::COORD_WIDTH,
  parameter int T_FRAC_BITS = sqi_pkg::T_FRAC_BITS,
  parameter int QUEUE_DEPTH = sqi_pkg::QUEUE_DEPTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // ax, ay, az, bx, by, bz: 21 bits each, from bit 0 up
  input  wire logic [sqi_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // cut in bit 0
  output logic [sqi_pkg::OUT_TDATA_W-1:0]      out_tdata,
  input  wire logic                            cfg_wen,
  input  wire logic [sqi_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  wire logic [sqi_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import sqi_pkg::*;

  localparam int IW = T_FRAC_BITS + 6 * COORD_WIDTH + 5;

  cfg_t          cfg_r;
  logic          f_valid, q_in_ready;
  logic [IW-1:0] f_item;
  logic          q_out_valid, q_out_ready;
  logic [IW-1:0] q_item;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.v1     <= '0;
      cfg_r.v2     <= '0;
      cfg_r.v3     <= '0;
      cfg_r.v4     <= '0;
      cfg_r.normal <= NORMAL_RESET;
      cfg_r.tol    <= TOL_RESET;
    end else if (cfg_wen) begin
      case (cfg_reg_t'(cfg_addr))
        REG_VERTEX_ONE:   cfg_r.v1     <= cfg_wdata[VERT_W-1:0];
        REG_VERTEX_TWO:   cfg_r.v2     <= cfg_wdata[VERT_W-1:0];
        REG_VERTEX_THREE: cfg_r.v3     <= cfg_wdata[VERT_W-1:0];
        REG_VERTEX_FOUR:  cfg_r.v4     <= cfg_wdata[VERT_W-1:0];
        REG_PLANE_NORMAL: cfg_r.normal <= cfg_wdata[NORMAL_REG_W-1:0];
        REG_TOLERANCE:    cfg_r.tol    <= cfg_wdata[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // plane distances, classification and divider
  sqi_front #(.COORD_WIDTH(COORD_WIDTH), .T_FRAC_BITS(T_FRAC_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .in_valid(in_tvalid), .in_ready(in_tready), .in_data(in_tdata),
    .out_valid(f_valid), .out_ready(q_in_ready), .out_item(f_item)
  );

  sqi_queue #(.WIDTH(IW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .in_valid(f_valid), .in_ready(q_in_ready), .in_data(f_item),
    .out_valid(q_out_valid), .out_ready(q_out_ready), .out_data(q_item)
  );

  // crossing point and edge tests
  sqi_back #(.COORD_WIDTH(COORD_WIDTH), .T_FRAC_BITS(T_FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .in_valid(q_out_valid), .in_ready(q_out_ready), .in_item(q_item),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_data(out_tdata)
  );

  // nothing is pending right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> (!out_tvalid && !q_out_valid))
    else $error("pipeline not empty after reset");

  // the back side holds the queue only while the output is stalled
  a_back_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (q_out_valid && !q_out_ready) |-> (out_tvalid && !out_tready))
    else $error("back stalled without output backpressure");

  // a full queue blocks new input transfers while the front holds a finished item
  a_front_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (f_valid && !q_in_ready) |-> !in_tready)
    else $error("input accepted while front is blocked");

endmodule
`default_nettype wire
